@@ hw/rtl/mm_pkg.sv @@
// Package for the matrix multiplier: item kinds, register indexes,
// sequencer states and fixed field widths.
// No dependencies.
package mm_pkg;

	localparam int VAL_W = 32;
	localparam int DIM_W = 4;
	localparam int POS_W = 3;

	// Every size register reads eight after reset, whatever the store depth.
	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	typedef enum logic [1:0] {
		KIND_LOAD_A = 2'd0,
		KIND_LOAD_B = 2'd1,
		KIND_START  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_A_ROWS     = 2'd0,
		REG_INNER_SIZE = 2'd1,
		REG_B_COLS     = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

endpackage

@@ hw/rtl/matrix_multiply.sv @@
// Matrix multiplier top level: operand stores, multiply-accumulate pipeline,
// result register and register port.
// Depends on mm_pkg.
//
// Usage:
// The input channel carries requests that load one element of A or B into
// on-chip stores, or start a multiply. A load produces no result. A start
// makes the block emit every element of C = A x B in row-major order on
// the output channel, with last set on the final one.
// Sizes come from the a_rows, inner_size and b_cols registers; a load
// outside them is dropped. Write registers only while the block is idle.
// Each element of C is built by one multiply-accumulate per cycle through
// a single 32x32 multiplier, after which the read, multiply and accumulate
// stages drain. in_stall stays high throughout a multiply.
// A result waits in the output register while out_stall is high; the next
// element is computed meanwhile and held in the accumulator until the
// register frees up. After reset the registers read 8 and no result is
// pending; the operand stores are undefined until written.
module matrix_multiply
	import mm_pkg::*;
#(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              kind,
	input  logic [POS_W-1:0]        row,
	input  logic [POS_W-1:0]        col,
	input  logic signed [VAL_W-1:0] element_value,
	// Output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [POS_W-1:0]        out_row,
	output logic [POS_W-1:0]        out_col,
	output logic signed [VAL_W-1:0] product_value,
	output logic                    saturated,
	output logic                    last,
	// Register port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [3:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_DIM);
	localparam int ACC_W = 2 * VAL_W + $clog2(MAX_DIM);
	localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

	// Configuration registers
	logic [DIM_W-1:0] a_rows_q, inner_size_q, b_cols_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q     <= DIM_RESET;
			inner_size_q <= DIM_RESET;
			b_cols_q     <= DIM_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_A_ROWS:     a_rows_q     <= pwdata[DIM_W-1:0];
				REG_INNER_SIZE: inner_size_q <= pwdata[DIM_W-1:0];
				REG_B_COLS:     b_cols_q     <= pwdata[DIM_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_A_ROWS:     prdata = 32'(a_rows_q);
			REG_INNER_SIZE: prdata = 32'(inner_size_q);
			REG_B_COLS:     prdata = 32'(b_cols_q);
			default:        prdata = '0;
		endcase
	end

	// A size of zero acts as one, and sizes above the store act as the maximum.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > MAX_D)
			r = MAX_D;
		else
			r = v;
		return r;
	endfunction

	logic [DIM_W-1:0] m_eff, kn_eff, n_eff, m_last, kn_last, n_last;

	assign m_eff   = eff_dim(a_rows_q);
	assign kn_eff  = eff_dim(inner_size_q);
	assign n_eff   = eff_dim(b_cols_q);
	assign m_last  = m_eff - DIM_W'(1);
	assign kn_last = kn_eff - DIM_W'(1);
	assign n_last  = n_eff - DIM_W'(1);

	// Sequencer
	state_t        state_q, state_d;
	logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic          issue, finish, elem_last, out_free, in_acc;
	logic          done_q;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		i_d       = i_q;
		j_d       = j_q;
		k_d       = k_q;
		issue     = 1'b0;
		finish    = 1'b0;
		elem_last = (DIM_W'(i_q) == m_last) && (DIM_W'(j_q) == n_last);
		in_stall  = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid && kind_t'(kind) == KIND_START) begin
					i_d     = '0;
					j_d     = '0;
					k_d     = '0;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (DIM_W'(k_q) == kn_last) begin
					k_d     = '0;
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + IW'(1);
				end
			end
			ST_DRAIN: begin
				if (done_q && out_free) begin
					finish = 1'b1;
					if (DIM_W'(j_q) == n_last) begin
						j_d = '0;
						if (DIM_W'(i_q) == m_last) begin
							state_d = ST_IDLE;
						end else begin
							i_d     = i_q + IW'(1);
							state_d = ST_RUN;
						end
					end else begin
						j_d     = j_q + IW'(1);
						state_d = ST_RUN;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Operand stores
	logic [VAL_W-1:0] a_store_q [DEPTH];
	logic [VAL_W-1:0] b_store_q [DEPTH];
	logic [AW-1:0]    wr_addr, rd_addr_a, rd_addr_b;
	logic             wr_a, wr_b;

	assign wr_addr   = AW'(row * MAX_DIM + col);
	assign rd_addr_a = AW'(i_q * MAX_DIM + k_q);
	assign rd_addr_b = AW'(k_q * MAX_DIM + j_q);
	assign wr_a = in_acc && kind_t'(kind) == KIND_LOAD_A
		&& DIM_W'(row) < m_eff && DIM_W'(col) < kn_eff;
	assign wr_b = in_acc && kind_t'(kind) == KIND_LOAD_B
		&& DIM_W'(row) < kn_eff && DIM_W'(col) < n_eff;

	always_ff @(posedge clk) begin
		if (wr_a)
			a_store_q[wr_addr] <= element_value;
		if (wr_b)
			b_store_q[wr_addr] <= element_value;
	end

	// Stage 1: registered store reads.
	logic signed [VAL_W-1:0] a_rd_s1, b_rd_s1;
	logic                    vld_s1, first_s1, last_s1;

	always_ff @(posedge clk) begin
		a_rd_s1 <= a_store_q[rd_addr_a];
		b_rd_s1 <= b_store_q[rd_addr_b];
	end

	// Stage 2: product.
	logic signed [2*VAL_W-1:0] prod_s2;
	logic                      vld_s2, first_s2, last_s2;

	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			vld_s2   <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			vld_s1   <= issue;
			first_s1 <= issue && k_q == '0;
			last_s1  <= issue && DIM_W'(k_q) == kn_last;
			vld_s2   <= vld_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
	end

	// Stage 3: accumulator, wide enough for the exact sum of all products.
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			if (first_s2)
				acc_q <= ACC_W'(prod_s2);
			else
				acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else if (vld_s2 && last_s2)
			done_q <= 1'b1;
		else if (finish)
			done_q <= 1'b0;
	end

	// Scaling and saturation: the value fits when every bit above bit 31
	// matches the sign of the low word.
	logic signed [ACC_W-1:0] acc_sh;
	logic                    fits;

	assign acc_sh = acc_q >>> FRAC_BITS;
	assign fits   = (&acc_sh[ACC_W-1:VAL_W-1]) || !(|acc_sh[ACC_W-1:VAL_W-1]);

	// Result register
	logic                    out_valid_q, sat_q, last_q;
	logic [POS_W-1:0]        out_row_q, out_col_q;
	logic signed [VAL_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (finish)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_row_q <= POS_W'(i_q);
			out_col_q <= POS_W'(j_q);
			last_q    <= elem_last;
			sat_q     <= !fits;
			if (fits)
				value_q <= acc_sh[VAL_W-1:0];
			else if (acc_q[ACC_W-1])
				value_q <= {1'b1, {(VAL_W-1){1'b0}}};
			else
				value_q <= {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	assign out_valid     = out_valid_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign product_value = value_q;
	assign saturated     = sat_q;
	assign last          = last_q;

`ifndef NO_ASSERTIONS
	// A finished sum must never land on one that is still waiting for the
	// result register.
	a_no_sum_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && last_s2 |-> !done_q)
		else $error("accumulated sum overwritten before it was taken");

	// When the sequencer is idle the pipeline holds no work.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !vld_s1 && !vld_s2 && !done_q)
		else $error("pipeline busy while sequencer idle");

	// The inner index stays inside the configured inner size.
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> DIM_W'(k_q) <= kn_last)
		else $error("inner index beyond inner size");

	// A result is only produced when the register is free to take it.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> !out_valid_q || !out_stall)
		else $error("result loaded over a stalled result");
`endif

endmodule
